>>> src/phtt_pkg.sv
// ----------------------------------------------------------------------------
// phtt_pkg: shared types and constants for the triangular-probe hash table
// Transfer payloads, command codes and the memory request bundle.
// ----------------------------------------------------------------------------
package phtt_pkg;

  localparam int KEY_W           = 16;
  localparam int SLOT_W          = 7;
  localparam int TABLE_SLOTS_DEF = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  // single-port access: a cycle either reads or writes one slot
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  wr_data;
  } mem_req_t;

endpackage

>>> src/pointer_hash_table_triangular_probe.sv
// ----------------------------------------------------------------------------
// pointer_hash_table_triangular_probe: open-addressed key table
// Insert, remove and find of nonzero 16-bit keys with triangular probing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (command, key) with req_valid/req_stall; one
//   response (ok, slot) leaves on rsp with rsp_valid/rsp_stall for each.
//   A request is taken only while the block is free; req_stall is high from
//   the transfer until its result has been moved into the output register.
//   Steps: the key-modulo step and the load of the first probe position,
//   then one memory read per probe (p probes, 1 to TABLE_SLOTS, one per
//   cycle), then one write for insert or remove and the load of the output
//   register; find skips the write. The single memory port is read once
//   per probe. A zero key or unused command answers ok 0, slot 0.
//   The output register lets the next request start while a response still
//   waits; if the receiver keeps stalling, the next result holds in the
//   block and req_stall stays high.
//   Reset empties the table at once (per-slot valid flags) and drops any
//   pending response.
// ----------------------------------------------------------------------------
module pointer_hash_table_triangular_probe #(
  parameter int TABLE_SLOTS = phtt_pkg::TABLE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  phtt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output phtt_pkg::rsp_t rsp
);
  import phtt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W:0]   NUM  = (IDX_W+1)'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOME,
    ST_PROBE,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t            state;
  logic [1:0]        cmd;
  logic [KEY_W-1:0]  key;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  cnt;
  logic              issuing;
  logic              rd_v;
  logic [IDX_W-1:0]  rd_pos;
  logic              rd_last;
  logic              res_ok;
  logic [SLOT_W-1:0] res_slot;

  logic              accept;
  logic              good;
  logic              out_free;
  logic              home_done;
  logic [IDX_W-1:0]  home;
  logic [IDX_W:0]    sum;
  logic [IDX_W-1:0]  addr_next;
  logic [KEY_W-1:0]  want;
  logic [KEY_W-1:0]  rd_data;
  logic              match;
  mem_req_t          mreq;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign good      = (req.key != '0) &&
                     (req.command == CMD_INSERT || req.command == CMD_REMOVE ||
                      req.command == CMD_FIND);
  assign out_free  = !rsp_valid || !rsp_stall;

  // next probe position: add the probe number, wrap once
  always_comb begin
    sum       = {1'b0, addr} + {1'b0, cnt} + (IDX_W+1)'(1);
    addr_next = (sum >= NUM) ? IDX_W'(sum - NUM) : sum[IDX_W-1:0];
  end

  // compare the slot just read against an empty slot or the key
  assign want  = (cmd == CMD_INSERT) ? '0 : key;
  assign match = rd_v && (rd_data == want);

  // memory access: probe reads, then one write-back
  always_comb begin
    mreq.rd_en   = (state == ST_PROBE) && issuing;
    mreq.wr_en   = (state == ST_WRITE);
    mreq.addr    = (state == ST_WRITE) ? res_slot : SLOT_W'(addr);
    mreq.wr_data = (cmd == CMD_INSERT) ? key : '0;
  end

  phtt_home #(.TABLE_SLOTS(TABLE_SLOTS)) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (accept && good),
    .key   (req.key),
    .done  (home_done),
    .home  (home)
  );

  phtt_mem #(.TABLE_SLOTS(TABLE_SLOTS)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      issuing   <= 1'b0;
      rd_v      <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd <= req.command;
            key <= req.key;
            if (good) begin
              state <= ST_HOME;
            end else begin
              res_ok   <= 1'b0;
              res_slot <= '0;
              state    <= ST_DONE;
            end
          end
        end
        ST_HOME: begin
          if (home_done) begin
            addr    <= home;
            cnt     <= '0;
            issuing <= 1'b1;
            rd_v    <= 1'b0;
            state   <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          // issue the next read while the previous one is checked
          rd_v <= issuing;
          if (issuing) begin
            rd_pos  <= addr;
            rd_last <= (cnt == LAST);
            if (cnt == LAST) begin
              issuing <= 1'b0;
            end else begin
              addr <= addr_next;
              cnt  <= cnt + 1'b1;
            end
          end
          // first hit wins; stop issuing and drop reads in flight
          if (match) begin
            res_ok   <= 1'b1;
            res_slot <= SLOT_W'(rd_pos);
            issuing  <= 1'b0;
            rd_v     <= 1'b0;
            state    <= (cmd == CMD_FIND) ? ST_DONE : ST_WRITE;
          end else if (rd_v && rd_last) begin
            res_ok   <= 1'b0;
            res_slot <= '0;
            rd_v     <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_WRITE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp.ok    <= res_ok;
            rsp.slot  <= res_slot;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a failed operation never reports a slot
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.slot == '0)
    else $error("failed response carries a nonzero slot");

  // a reported slot lies inside the table
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> {1'b0, rsp.slot} < (SLOT_W+1)'(TABLE_SLOTS))
    else $error("response slot beyond table size");

  // the table is written only after a successful probe
  a_write_after_hit: assert property (@(posedge clk) disable iff (rst)
    mreq.wr_en |-> res_ok && $past(state) == ST_PROBE)
    else $error("table written without a matching probe");

  // a new request is held off in the cycle after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("request taken while another is in progress");

endmodule

>>> src/phtt_home.sv
// ----------------------------------------------------------------------------
// phtt_home: home slot unit
// Reduces a key modulo the slot count: a reciprocal multiply estimates the
// quotient, then a multiply-back and one correcting subtract.
// ----------------------------------------------------------------------------
module phtt_home #(
  parameter int TABLE_SLOTS = phtt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [phtt_pkg::KEY_W-1:0]        key,
  output logic                              done,
  output logic [$clog2(TABLE_SLOTS)-1:0]    home
);
  import phtt_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int PROD_W = KEY_W + 32;
  localparam int MUL_W  = KEY_W + 8;
  localparam logic [31:0]      RECIP = 32'((64'd1 << 32) / TABLE_SLOTS);
  localparam logic [IDX_W:0]   NUM   = (IDX_W+1)'(TABLE_SLOTS);
  localparam logic [MUL_W-1:0] NUM_W = MUL_W'(TABLE_SLOTS);

  logic              busy;
  logic [KEY_W-1:0]  kq;
  logic [KEY_W-1:0]  quo;
  logic [PROD_W-1:0] prod;
  logic [MUL_W-1:0]  back;
  logic [MUL_W-1:0]  diff;
  logic [IDX_W:0]    est;
  logic [IDX_W:0]    red;
  logic [IDX_W-1:0]  rem;

  // estimate the quotient; the truncated reciprocal leaves it exact or one low
  assign prod = PROD_W'(key) * PROD_W'(RECIP);

  // multiply back, subtract, then one conditional subtract keeps rem below NUM
  always_comb begin
    back = MUL_W'(quo) * NUM_W;
    diff = MUL_W'(kq) - back;
    est  = diff[IDX_W:0];
    red  = (est >= NUM) ? est - NUM : est;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
      if (start) begin
        kq  <= key;
        quo <= prod[PROD_W-1:32];
      end
      if (busy) begin
        rem <= red[IDX_W-1:0];
      end
    end
  end

  assign home = rem;

endmodule

>>> src/phtt_mem.sv
// ----------------------------------------------------------------------------
// phtt_mem: slot store
// Synchronous single-port memory with a registered read and per-slot valid
// flags; a slot never written since reset reads as empty (zero).
// ----------------------------------------------------------------------------
module phtt_mem #(
  parameter int TABLE_SLOTS = phtt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  phtt_pkg::mem_req_t          mreq,
  output logic [phtt_pkg::KEY_W-1:0]  rd_data
);
  import phtt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  logic [KEY_W-1:0]       mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] vld;
  logic [KEY_W-1:0]       dq;
  logic                   vq;
  logic [IDX_W-1:0]       idx;

  assign idx = mreq.addr[IDX_W-1:0];

  // write and registered read of the array
  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[idx] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      dq <= mem[idx];
    end
  end

  // valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      vq  <= 1'b0;
    end else begin
      if (mreq.wr_en) begin
        vld[idx] <= 1'b1;
      end
      if (mreq.rd_en) begin
        vq <= vld[idx];
      end
    end
  end

  assign rd_data = vq ? dq : '0;

endmodule
